// ===== hw/rtl/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: shared definitions
// Field widths, item mode codes and the result record passed to the output.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int DATA_W              = 32;
	localparam int INDEX_W             = 10;
	localparam int COUNT_W             = 11;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_EXACT = 2'd1,
		MODE_LOWER = 2'd2,
		MODE_UPPER = 2'd3
	} mode_t;

	typedef struct packed {
		logic [COUNT_W-1:0] position;
		logic               found;
	} result_t;

endpackage

// ===== hw/rtl/sbs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sbs_engine.sv =====
// ----------------------------------------------------------------------------
// Search sequencer
// Writes loaded entries and runs one table probe per cycle for a search.
// ----------------------------------------------------------------------------
module sbs_engine
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     busy,
	input  logic [1:0]               mode,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic signed [DATA_W-1:0] key_value,
	input  logic [COUNT_W-1:0]       active_count,
	output logic                     ram_we,
	output logic                     ram_re,
	output logic [AW-1:0]            ram_addr,
	output logic [DATA_W-1:0]        ram_wdata,
	input  logic [DATA_W-1:0]        ram_rdata,
	input  logic                     out_free,
	output logic                     res_push,
	output result_t                  res
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_PROBE  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                   state_q, state_d;
	logic [COUNT_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic signed [DATA_W-1:0] key_q, key_d;
	mode_t                    mode_q, mode_d;
	result_t                  res_q, res_d;

	logic signed [DATA_W-1:0] probe;
	logic                     hit, go_left;
	logic [COUNT_W-1:0]       nlo, nhi, nmid;

	assign probe   = $signed(ram_rdata);
	assign hit     = (probe == key_q);
	assign go_left = (mode_q == MODE_LOWER) ? (probe >= key_q) : (probe > key_q);
	assign nlo     = go_left ? lo_q : mid_q + COUNT_W'(1);
	assign nhi     = go_left ? mid_q : hi_q;
	assign nmid    = nlo + ((nhi - nlo) >> 1);

	assign ram_wdata = key_value;

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		key_d    = key_q;
		mode_d   = mode_q;
		res_d    = res_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = AW'(mid_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_LOAD) begin
						ram_we   = (32'(entry_index) < 32'(TABLE_DEPTH));
						ram_addr = AW'(entry_index);
					end else begin
						key_d  = key_value;
						mode_d = mode_t'(mode);
						lo_d   = '0;
						hi_d   = active_count;
						mid_d  = active_count >> 1;
						if (active_count != '0) begin
							ram_re   = 1'b1;
							ram_addr = AW'(active_count >> 1);
							state_d  = ST_PROBE;
						end else begin
							res_d.position = '0;
							res_d.found    = (mode != MODE_EXACT);
							state_d        = ST_FINISH;
						end
					end
				end
			end
			ST_PROBE: begin
				if (mode_q == MODE_EXACT && hit) begin
					res_d.position = mid_q;
					res_d.found    = 1'b1;
					state_d        = ST_FINISH;
				end else begin
					lo_d  = nlo;
					hi_d  = nhi;
					mid_d = nmid;
					if (nlo < nhi) begin
						ram_re   = 1'b1;
						ram_addr = AW'(nmid);
					end else begin
						res_d.position = (mode_q == MODE_EXACT) ? '0 : nlo;
						res_d.found    = (mode_q != MODE_EXACT);
						state_d        = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		key_q  <= key_d;
		mode_q <= mode_d;
		res_q  <= res_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign res_push = (state_q == ST_FINISH) && out_free;
	assign res      = res_q;

endmodule

// ===== hw/rtl/sorted_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds an ascending table of signed values and answers exact, lower-bound
// and upper-bound searches over the first element_count entries.
//
// The input channel carries mode, entry_index and key_value; a transaction
// takes place when in_valid is high and in_stall is low. A load transaction
// writes one table entry and produces no result. A search transaction produces
// one result transaction (position, found) on the output channel.
// A search issues its first read from the idle state, reads the single table
// RAM port once per halving of the range in the probe state (an exact search
// stops early on a hit), and hands the result over from the finish state.
// in_stall is high while a search is in progress. A finished result sits in
// the output register, so the next transaction is accepted while it waits;
// a result stalled by out_stall holds its payload and the following search
// waits at its end until the register frees up.
// Reset empties the output register and sets element_count to zero; table
// contents are undefined until written. The user must write element_count only
// while idle, via cfg_write_en/cfg_write_data; the block does not enforce it.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [COUNT_W-1:0]       cfg_write_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic signed [DATA_W-1:0] key_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [COUNT_W-1:0]       position,
	output logic                     found
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [COUNT_W-1:0] element_count_q;
	logic [COUNT_W-1:0] active_count;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_addr;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata;
	logic               out_free, res_push;
	result_t            res;
	logic               out_valid_q;
	logic [COUNT_W-1:0] position_q;
	logic               found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_write_en) begin
			element_count_q <= cfg_write_data;
		end
	end

	assign active_count = (32'(element_count_q) > 32'(TABLE_DEPTH)) ?
		COUNT_W'(TABLE_DEPTH) : element_count_q;

	sbs_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.busy         (in_stall),
		.mode         (mode),
		.entry_index  (entry_index),
		.key_value    (key_value),
		.active_count (active_count),
		.ram_we       (ram_we),
		.ram_re       (ram_re),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata),
		.ram_rdata    (ram_rdata),
		.out_free     (out_free),
		.res_push     (res_push),
		.res          (res)
	);

	sbs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			position_q <= res.position;
			found_q    <= res.found;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign found     = found_q;

endmodule
